FILE: sv/a64_pkg.sv
// Package for the A64 integer execute core: instruction classes, flag helpers
// and the result beat layout. No dependencies.
package a64_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned DataW = 64;
    localparam logic [3:0] FlagsReset = 4'b0100;

    typedef enum logic [3:0] {
        CLS_ADDI,
        CLS_MOVW,
        CLS_LOGIC,
        CLS_ADDR,
        CLS_MADD,
        CLS_B,
        CLS_BCOND,
        CLS_BR,
        CLS_BAD
    } instr_cls_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr_valid;
        logic [4:0]  wr_index;
        logic [63:0] wr_data;
        logic [3:0]  nzcv;
        logic        unknown_instr;
    } result_t;

    function automatic instr_cls_t decode_cls(input logic [31:0] w);
        instr_cls_t c;
        c = CLS_BAD;
        if (w[28:23] == 6'h22) begin
            c = CLS_ADDI;
        end else if (w[28:23] == 6'h25) begin
            if (w[30:29] == 2'b01 || (!w[31] && w[22])) c = CLS_BAD;
            else c = CLS_MOVW;
        end else if (w[28:24] == 5'h0A) begin
            if (!w[31] && w[15]) c = CLS_BAD;
            else c = CLS_LOGIC;
        end else if (w[28:24] == 5'h0B && !w[21]) begin
            if (w[23:22] == 2'b11 || (!w[31] && w[15])) c = CLS_BAD;
            else c = CLS_ADDR;
        end else if (w[30:21] == 10'h0D8) begin
            c = CLS_MADD;
        end else if (w[31:26] == 6'h05) begin
            c = CLS_B;
        end else if (w[31:24] == 8'h54 && !w[4]) begin
            c = CLS_BCOND;
        end else if ((w & 32'hFFFFFC1F) == 32'hD61F0000) begin
            c = CLS_BR;
        end
        return c;
    endfunction

    function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
        logic r;
        unique case (cond[3:1])
            3'd0: r = f[2];
            3'd1: r = f[1];
            3'd2: r = f[3];
            3'd3: r = f[0];
            3'd4: r = f[1] & ~f[2];
            3'd5: r = (f[3] == f[0]);
            3'd6: r = ~f[2] & (f[3] == f[0]);
            default: r = 1'b1;
        endcase
        if (cond[0] && cond != 4'hF) r = ~r;
        return r;
    endfunction

    function automatic logic [63:0] shift_op(input logic [63:0] v, input logic [5:0] amt,
                                             input logic [1:0] kind, input logic wide);
        logic [63:0] r;
        logic [31:0] v32;
        logic [31:0] r32;
        logic [4:0]  a32;
        v32 = v[31:0];
        a32 = amt[4:0];
        r = v;
        r32 = v32;
        if (wide) begin
            case (kind)
                2'd0: r = v << amt;
                2'd1: r = v >> amt;
                2'd2: r = 64'($signed(v) >>> amt);
                default: r = (v >> amt) | (v << (7'd64 - {1'b0, amt}));
            endcase
        end else begin
            case (kind)
                2'd0: r32 = v32 << a32;
                2'd1: r32 = v32 >> a32;
                2'd2: r32 = 32'($signed(v32) >>> a32);
                default: r32 = (v32 >> a32) | (v32 << (6'd32 - {1'b0, a32}));
            endcase
            r = {32'd0, r32};
        end
        return r;
    endfunction

endpackage

FILE: sv/a64_integer_execute_core.sv
// Top level of the A64 integer execute core: register file memory with
// forwarding, PC and flags, output register. Depends on a64_pkg and a64_alu.
//
// channel | dir | tdata                          | tuser
// s_      | in  | instr_word[31:0]               | -
// m_      | out | next_pc, wr_data, nzcv ...     | -
//
// One instruction per cycle. Stage 1 reads four register-file ports;
// stage 2 executes and writes back, forwarding the write to a following
// read of the same register. Reset runs a clearing pass over all
// NUM_GP_REGS register-file entries; s_tready is low meanwhile.
// A stalled output holds both stages.
module a64_integer_execute_core #(
    parameter int NUM_GP_REGS = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // instr_word[31:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[31:0] wr_valid[32] wr_index[37:33] wr_data[101:38]
    // nzcv[105:102] unknown_instr[106], zero fill to 111
    output logic [111:0] m_tdata
);
    import a64_pkg::*;

    localparam int IdxW = $clog2(NUM_GP_REGS + 1);

    logic [63:0]     rf_mem [NUM_GP_REGS];
    logic [IdxW-1:0] clr_reg;
    logic            clr_next_done;
    logic            clearing_reg;

    logic            s1_valid_reg;
    logic [31:0]     s1_instr_reg;
    logic [63:0]     rd_n_reg, rd_m_reg, rd_a_reg, rd_d_reg;
    logic [31:0]     pc_reg;
    logic [3:0]      flags_reg;
    logic            out_valid_reg;
    result_t         out_reg;
    result_t         res;
    logic            adv;
    logic            take;
    logic [63:0]     op_n, op_m, op_a, op_d;

    assign adv = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || adv);
    assign take = s_tvalid && s_tready;
    assign clr_next_done = (clr_reg == IdxW'(NUM_GP_REGS - 1));

    function automatic logic [63:0] fwd(input logic [4:0] idx, input logic [63:0] mem_v,
                                        input result_t r, input logic hit_ok);
        return (hit_ok && r.wr_valid && r.wr_index == idx) ? r.wr_data : mem_v;
    endfunction

    // register file reads see the write retiring in the same edge
    always_ff @(posedge aclk) begin
        if (take) begin
            rd_n_reg <= (s_tdata[9:5] == 5'd31) ? '0 :
                fwd(s_tdata[9:5], rf_mem[s_tdata[9:5]], res, adv);
            rd_m_reg <= (s_tdata[20:16] == 5'd31) ? '0 :
                fwd(s_tdata[20:16], rf_mem[s_tdata[20:16]], res, adv);
            rd_a_reg <= (s_tdata[14:10] == 5'd31) ? '0 :
                fwd(s_tdata[14:10], rf_mem[s_tdata[14:10]], res, adv);
            rd_d_reg <= (s_tdata[4:0] == 5'd31) ? '0 :
                fwd(s_tdata[4:0], rf_mem[s_tdata[4:0]], res, adv);
            s1_instr_reg <= s_tdata;
        end
        if (clearing_reg) rf_mem[clr_reg[4:0]] <= '0;
        else if (adv && res.wr_valid) rf_mem[res.wr_index] <= res.wr_data;
    end

    assign op_n = rd_n_reg;
    assign op_m = rd_m_reg;
    assign op_a = rd_a_reg;
    assign op_d = rd_d_reg;

    a64_alu u_alu (
        .instr (s1_instr_reg),
        .op_n  (op_n),
        .op_m  (op_m),
        .op_a  (op_a),
        .op_d  (op_d),
        .pc    (pc_reg),
        .flags (flags_reg),
        .res   (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            flags_reg     <= FlagsReset;
        end else begin
            if (clearing_reg) begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_next_done) clearing_reg <= 1'b0;
            end
            if (take) s1_valid_reg <= 1'b1;
            else if (adv) s1_valid_reg <= 1'b0;
            if (adv) begin
                out_valid_reg <= 1'b1;
                pc_reg        <= res.next_pc;
                flags_reg     <= res.nzcv;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'd0, out_reg.unknown_instr, out_reg.nzcv, out_reg.wr_data,
                      out_reg.wr_index, out_reg.wr_valid, out_reg.next_pc};
endmodule

FILE: sv/a64_alu.sv
// Execute stage for the A64 core: operand shift, add/sub, logic, moves,
// multiply-add/subtract and branch target. Depends on a64_pkg.
module a64_alu (
    input  logic [31:0]        instr,
    input  logic [63:0]        op_n,
    input  logic [63:0]        op_m,
    input  logic [63:0]        op_a,
    input  logic [63:0]        op_d,
    input  logic [31:0]        pc,
    input  logic [3:0]         flags,
    output a64_pkg::result_t   res
);
    import a64_pkg::*;

    instr_cls_t  cls;
    logic        wide;
    logic [63:0] msk;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] bs;
    logic [63:0] sum;
    logic        c32;
    logic        c64;
    logic [3:0]  as_flags;
    logic [63:0] mul_n;
    logic [63:0] mul_m;
    logic [63:0] p_ll;
    logic [31:0] p_lh;
    logic [31:0] p_hl;
    logic [63:0] prod;
    logic [63:0] value;
    logic [63:0] imm16;
    logic [5:0]  pos;
    logic [3:0]  nf;
    logic        writes;
    logic [31:0] pc4;
    logic [31:0] pcn;

    always_comb begin
        cls = decode_cls(instr);
        wide = instr[31];
        msk = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
        pc4 = pc + 32'd4;
        pcn = pc4;
        nf = flags;
        writes = 1'b0;
        value = '0;
        a = op_n & msk;
        if (cls == CLS_ADDI) b = instr[22] ? {40'd0, instr[21:10], 12'd0}
                                           : {52'd0, instr[21:10]};
        else b = shift_op(op_m & msk, instr[15:10], instr[23:22], wide);
        bs = (instr[30] ? ~b : b) & msk;
        {c64, sum} = {1'b0, a} + {1'b0, bs} + 65'(instr[30]);
        c32 = sum[32];
        if (!wide) sum = sum & msk;
        as_flags = {wide ? sum[63] : sum[31], sum == '0, wide ? c64 : c32,
                    wide ? ((a[63] ^ sum[63]) & (bs[63] ^ sum[63]))
                         : ((a[31] ^ sum[31]) & (bs[31] ^ sum[31]))};
        // low 64 bits of the product from 32x32 partial products
        mul_n = op_n & msk;
        mul_m = op_m & msk;
        p_ll = {32'd0, mul_n[31:0]} * {32'd0, mul_m[31:0]};
        p_lh = mul_n[31:0] * mul_m[63:32];
        p_hl = mul_n[63:32] * mul_m[31:0];
        prod = p_ll + {p_lh + p_hl, 32'd0};
        imm16 = {48'd0, instr[20:5]};
        pos = {instr[22:21], 4'd0};
        unique case (cls)
            CLS_ADDI, CLS_ADDR: begin
                value = sum;
                writes = 1'b1;
                if (instr[29]) nf = as_flags;
            end
            CLS_MOVW: begin
                writes = 1'b1;
                case (instr[30:29])
                    2'b11: value = (op_d & ~(64'hFFFF << pos)) | (imm16 << pos);
                    2'b00: value = ~(imm16 << pos);
                    default: value = imm16 << pos;
                endcase
                value = value & msk;
            end
            CLS_LOGIC: begin
                writes = 1'b1;
                if (instr[21]) b = ~b & msk;
                case (instr[30:29])
                    2'b01: value = a | b;
                    2'b10: value = a ^ b;
                    default: value = a & b;
                endcase
                if (instr[30:29] == 2'b11)
                    nf = {wide ? value[63] : value[31], value == '0, 2'b00};
            end
            CLS_MADD: begin
                writes = 1'b1;
                value = (instr[15] ? (op_a & msk) - prod : (op_a & msk) + prod) & msk;
            end
            CLS_B: pcn = pc + {instr[25], instr[25], instr[25], instr[25], instr[25:0], 2'b00};
            CLS_BCOND:
                if (cond_holds(instr[3:0], flags))
                    pcn = pc + {{11{instr[23]}}, instr[23:5], 2'b00};
            CLS_BR: pcn = op_n[31:0];
            default: ;
        endcase
        if (instr[4:0] == 5'd31) writes = 1'b0;
        res.next_pc = pcn;
        res.wr_valid = writes;
        res.wr_index = writes ? instr[4:0] : 5'd0;
        res.wr_data = writes ? value : 64'd0;
        res.nzcv = nf;
        res.unknown_instr = (cls == CLS_BAD);
    end
endmodule
